// File: rtl/core/cadq_pkg.sv
// Shared constants, operation codes and beat types of the circular array deque.
`default_nettype none

package cadq_pkg;

    localparam int unsigned DEPTH      = 16;
    localparam int unsigned IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W      = $clog2(DEPTH + 1);
    localparam int unsigned WORD_W     = 32;
    localparam int unsigned ITEM_CNT_W = 5;
    localparam int unsigned OP_W       = 3;

    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_REAR  = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_REAR   = 3'd3;
    localparam logic [OP_W-1:0] OP_PEEK_FRONT = 3'd4;
    localparam logic [OP_W-1:0] OP_PEEK_REAR  = 3'd5;

    typedef struct packed {
        logic [OP_W-1:0]          operation;
        logic signed [WORD_W-1:0] item_value;
    } t_cmd;

    typedef struct packed {
        logic                     ok;
        logic signed [WORD_W-1:0] data_out;
        logic                     is_empty;
        logic                     is_full;
        logic [ITEM_CNT_W-1:0]    item_count;
    } t_rsp;

endpackage

`default_nettype wire

// File: rtl/core/circular_array_deque_unit.sv
// Top level of the circular array deque: pointer control and slot memory.
//
// One command beat is taken in every cycle (busy stays low) and its result
// beat appears on o_rsp, flagged by o_rsp_valid, in the cycle after the
// beat is taken, as the slot memory read is registered. Pointers
// and count update at the edge that takes the command, so back-to-back
// commands always see the state the previous one left. The result beat is
// shown for one cycle only and cannot be held off: capture it when it appears.
// Slots never written are never read, so no memory clearing is done.
`default_nettype none

module circular_array_deque_unit (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire cadq_pkg::t_cmd i_cmd,
    output logic               o_rsp_valid,
    output cadq_pkg::t_rsp     o_rsp
);

    function automatic logic [cadq_pkg::IDX_W-1:0] wrap_up(
        input logic [cadq_pkg::IDX_W-1:0] i
    );
        return (i == cadq_pkg::IDX_W'(cadq_pkg::DEPTH - 1)) ? '0 : i + 1'b1;
    endfunction

    function automatic logic [cadq_pkg::IDX_W-1:0] wrap_down(
        input logic [cadq_pkg::IDX_W-1:0] i
    );
        return (i == '0) ? cadq_pkg::IDX_W'(cadq_pkg::DEPTH - 1) : i - 1'b1;
    endfunction

    logic [cadq_pkg::WORD_W-1:0] r_mem [cadq_pkg::DEPTH];
    logic [cadq_pkg::WORD_W-1:0] r_rd_data;

    logic [cadq_pkg::IDX_W-1:0]  r_head, n_head;
    logic [cadq_pkg::IDX_W-1:0]  r_tail, n_tail;
    logic [cadq_pkg::CNT_W-1:0]  r_count, n_count;
    logic                        r_rsp_valid;
    logic                        r_ok, n_ok;
    logic                        r_use_rd, n_use_rd;

    logic                        accept;
    logic                        wr_en;
    logic [cadq_pkg::IDX_W-1:0]  wr_addr;
    logic [cadq_pkg::IDX_W-1:0]  rd_addr;
    logic                        is_empty_now;
    logic                        is_full_now;

    assign busy         = 1'b0;
    assign accept       = start && !busy;
    assign is_empty_now = (r_count == '0);
    assign is_full_now  = (r_count == cadq_pkg::CNT_W'(cadq_pkg::DEPTH));

    always_comb begin
        n_head   = r_head;
        n_tail   = r_tail;
        n_count  = r_count;
        n_ok     = 1'b0;
        n_use_rd = 1'b0;
        wr_en    = 1'b0;
        wr_addr  = r_head;
        rd_addr  = ((i_cmd.operation == cadq_pkg::OP_POP_FRONT) ||
                    (i_cmd.operation == cadq_pkg::OP_PEEK_FRONT)) ? r_head : r_tail;
        if (accept) begin
            unique case (i_cmd.operation)
                cadq_pkg::OP_PUSH_FRONT, cadq_pkg::OP_PUSH_REAR: begin
                    if (!is_full_now) begin
                        n_ok    = 1'b1;
                        n_count = r_count + 1'b1;
                        wr_en   = 1'b1;
                        if (is_empty_now) begin
                            n_head  = '0;
                            n_tail  = '0;
                            wr_addr = '0;
                        end else if (i_cmd.operation == cadq_pkg::OP_PUSH_FRONT) begin
                            n_head  = wrap_down(r_head);
                            wr_addr = wrap_down(r_head);
                        end else begin
                            n_tail  = wrap_up(r_tail);
                            wr_addr = wrap_up(r_tail);
                        end
                    end
                end
                cadq_pkg::OP_POP_FRONT: begin
                    if (!is_empty_now) begin
                        n_ok     = 1'b1;
                        n_use_rd = 1'b1;
                        n_count  = r_count - 1'b1;
                        if (r_count != cadq_pkg::CNT_W'(1)) begin
                            n_head = wrap_up(r_head);
                        end
                    end
                end
                cadq_pkg::OP_POP_REAR: begin
                    if (!is_empty_now) begin
                        n_ok     = 1'b1;
                        n_use_rd = 1'b1;
                        n_count  = r_count - 1'b1;
                        if (r_count != cadq_pkg::CNT_W'(1)) begin
                            n_tail = wrap_down(r_tail);
                        end
                    end
                end
                cadq_pkg::OP_PEEK_FRONT, cadq_pkg::OP_PEEK_REAR: begin
                    if (!is_empty_now) begin
                        n_ok     = 1'b1;
                        n_use_rd = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= i_cmd.item_value;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_rsp_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ok     <= n_ok;
            r_use_rd <= n_use_rd;
        end
    end

    assign o_rsp_valid      = r_rsp_valid;
    assign o_rsp.ok         = r_ok;
    assign o_rsp.data_out   = r_use_rd ? r_rd_data : '1;
    assign o_rsp.is_empty   = is_empty_now;
    assign o_rsp.is_full    = is_full_now;
    assign o_rsp.item_count = cadq_pkg::ITEM_CNT_W'(r_count);

endmodule

`default_nettype wire

// File: rtl/core/cadq_chk.sv
// Port checker for the circular array deque, bound to the top level.
`default_nettype none

module cadq_chk (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           start,
    input wire logic           busy,
    input wire cadq_pkg::t_cmd i_cmd,
    input wire logic           o_rsp_valid,
    input wire cadq_pkg::t_rsp o_rsp
);

    a_rsp_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> o_rsp_valid)
        else $error("result beat missing after command beat");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(start && !busy) |=> !o_rsp_valid)
        else $error("result beat without command beat");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> (o_rsp.is_empty == (o_rsp.item_count == '0)))
        else $error("empty flag disagrees with count");

    a_full_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |->
            (o_rsp.is_full == (o_rsp.item_count ==
                               cadq_pkg::ITEM_CNT_W'(cadq_pkg::DEPTH))))
        else $error("full flag disagrees with count");

    a_fail_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && !o_rsp.ok) |-> (o_rsp.data_out == '1))
        else $error("failed command returned data");

endmodule

bind circular_array_deque_unit cadq_chk u_cadq_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .i_cmd       (i_cmd),
    .o_rsp_valid (o_rsp_valid),
    .o_rsp       (o_rsp)
);

`default_nettype wire

// File: tb/sv/deque_checker.sv
`timescale 1ns / 100ps
// Checker for the circular array deque: mirrors the deque and compares every result beat.
module deque_checker
    import cadq_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_start,
    input  wire logic i_busy,
    input  wire t_cmd i_cmd,
    input  wire logic i_rsp_valid,
    input  wire t_rsp i_rsp,
    output int        o_fail_count,
    output int        o_open_count
);

    logic signed [WORD_W-1:0] slot_mirror [DEPTH];
    int unsigned              front_idx;
    int unsigned              rear_idx;
    int unsigned              held;
    t_rsp                     awaited_rsp_q [$];

    function automatic int unsigned step_up(int unsigned idx);
        return (idx + 1 >= DEPTH) ? 0 : idx + 1;
    endfunction

    function automatic int unsigned step_down(int unsigned idx);
        return (idx == 0) ? DEPTH - 1 : idx - 1;
    endfunction

    function automatic t_rsp apply_deque_op(t_cmd cmd);
        t_rsp rsp;
        rsp.ok       = 1'b0;
        rsp.data_out = -1;
        case (cmd.operation)
            OP_PUSH_FRONT, OP_PUSH_REAR: begin
                if (held < DEPTH) begin
                    if (held == 0) begin
                        front_idx = 0;
                        rear_idx  = 0;
                        slot_mirror[0] = cmd.item_value;
                    end else if (cmd.operation == OP_PUSH_FRONT) begin
                        front_idx = step_down(front_idx);
                        slot_mirror[front_idx] = cmd.item_value;
                    end else begin
                        rear_idx = step_up(rear_idx);
                        slot_mirror[rear_idx] = cmd.item_value;
                    end
                    held++;
                    rsp.ok = 1'b1;
                end
            end
            OP_POP_FRONT, OP_PEEK_FRONT: begin
                if (held != 0) begin
                    rsp.data_out = slot_mirror[front_idx];
                    rsp.ok       = 1'b1;
                    if (cmd.operation == OP_POP_FRONT) begin
                        held--;
                        if (held != 0) front_idx = step_up(front_idx);
                    end
                end
            end
            OP_POP_REAR, OP_PEEK_REAR: begin
                if (held != 0) begin
                    rsp.data_out = slot_mirror[rear_idx];
                    rsp.ok       = 1'b1;
                    if (cmd.operation == OP_POP_REAR) begin
                        held--;
                        if (held != 0) rear_idx = step_down(rear_idx);
                    end
                end
            end
            default: begin
            end
        endcase
        rsp.is_empty   = (held == 0);
        rsp.is_full    = (held == DEPTH);
        rsp.item_count = held[ITEM_CNT_W-1:0];
        return rsp;
    endfunction

    task automatic report_mismatch(string what, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
        $display("%0t: mismatch in %s: expected %0h, got %0h", $time, what, want, got);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_rsp want;
        if (!i_rst_n) begin
            front_idx    = 0;
            rear_idx     = 0;
            held         = 0;
            o_fail_count = 0;
            awaited_rsp_q.delete();
        end else begin
            // retire the result beat before queueing the one just taken
            if (i_rsp_valid) begin
                if (awaited_rsp_q.size() == 0) begin
                    report_mismatch("unexpected result beat", '0, i_rsp.data_out);
                end else begin
                    want = awaited_rsp_q.pop_front();
                    if (i_rsp.ok !== want.ok)
                        report_mismatch("ok", WORD_W'(want.ok), WORD_W'(i_rsp.ok));
                    if (i_rsp.data_out !== want.data_out)
                        report_mismatch("data_out", want.data_out, i_rsp.data_out);
                    if (i_rsp.is_empty !== want.is_empty)
                        report_mismatch("is_empty", WORD_W'(want.is_empty),
                                        WORD_W'(i_rsp.is_empty));
                    if (i_rsp.is_full !== want.is_full)
                        report_mismatch("is_full", WORD_W'(want.is_full),
                                        WORD_W'(i_rsp.is_full));
                    if (i_rsp.item_count !== want.item_count)
                        report_mismatch("item_count", WORD_W'(want.item_count),
                                        WORD_W'(i_rsp.item_count));
                end
            end
            if (i_start && !i_busy)
                awaited_rsp_q.push_back(apply_deque_op(i_cmd));
        end
        o_open_count = awaited_rsp_q.size();
    end

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// Top of the deque testbench: clock, reset, command stimulus, watchdog and verdict.
module tb_top;
    import cadq_pkg::*;

    localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;
    localparam int RANDOM_BEATS  = 1500;
    localparam int PHASE_BEATS   = 48;
    localparam int QUIET_TAIL    = 200;
    localparam int STALL_LIMIT   = 1000;
    localparam int MODE_FILL     = 0;
    localparam int MODE_DRAIN    = 1;
    localparam int MODE_BALANCED = 2;

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    t_cmd i_cmd;
    logic o_rsp_valid;
    t_rsp o_rsp;
    int   fail_count;
    int   open_count;
    logic taken;
    bit   idling_on;
    int   stall_cycles = 0;

    circular_array_deque_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cmd       (i_cmd),
        .o_rsp_valid (o_rsp_valid),
        .o_rsp       (o_rsp)
    );

    deque_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_cmd        (i_cmd),
        .i_rsp_valid  (o_rsp_valid),
        .i_rsp        (o_rsp),
        .o_fail_count (fail_count),
        .o_open_count (open_count)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        taken <= i_rst_n && start && !busy;
    end

    always @(posedge i_clk) begin
        if ((i_rst_n && start && !busy) || o_rsp_valid) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic logic signed [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return -1;
            3:       return 0;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [OP_W-1:0] pick_op(int mode);
        int push_pct;
        int roll;
        push_pct = (mode == MODE_FILL) ? 70 : (mode == MODE_DRAIN) ? 20 : 45;
        roll = $urandom_range(0, 99);
        if (roll < 2)
            return $urandom_range(0, 1) ? OP_SPARE_HI : OP_SPARE_LO;
        if (roll < 2 + push_pct)
            return $urandom_range(0, 1) ? OP_PUSH_REAR : OP_PUSH_FRONT;
        case ($urandom_range(0, 9))
            0, 1:    return $urandom_range(0, 1) ? OP_PEEK_REAR : OP_PEEK_FRONT;
            default: return $urandom_range(0, 1) ? OP_POP_REAR : OP_POP_FRONT;
        endcase
    endfunction

    // call at a falling edge; returns at the falling edge after the beat is taken
    task automatic issue(logic [OP_W-1:0] op, logic signed [WORD_W-1:0] word);
        if (idling_on && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        start            <= 1'b1;
        i_cmd.operation  <= op;
        i_cmd.item_value <= word;
        do @(negedge i_clk); while (!taken);
    endtask

    initial begin
        int mode;
        idling_on    = 1'b0;
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_cmd        = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        issue(OP_POP_FRONT, 0);
        issue(OP_POP_REAR, 0);
        issue(OP_PEEK_FRONT, 0);
        issue(OP_PEEK_REAR, 0);
        issue(OP_SPARE_LO, 32'sh5A5A_5A5A);
        issue(OP_SPARE_HI, -1);
        for (int k = 0; k < DEPTH; k++) begin
            case (k % 4)
                0: issue(k[0] ? OP_PUSH_REAR : OP_PUSH_FRONT, 32'sh7FFF_FFFF);
                1: issue(k[0] ? OP_PUSH_REAR : OP_PUSH_FRONT, 32'sh8000_0000);
                2: issue(k[0] ? OP_PUSH_REAR : OP_PUSH_FRONT, -1);
                default: issue(k[0] ? OP_PUSH_REAR : OP_PUSH_FRONT, k);
            endcase
        end
        issue(OP_PUSH_REAR, 32'sh1234_5678);
        issue(OP_PEEK_FRONT, 0);
        issue(OP_PEEK_REAR, 0);

        // hold off until every result beat is in
        start <= 1'b0;
        while (open_count != 0) @(negedge i_clk);

        for (int n = 0; n < RANDOM_BEATS; n++) begin
            if (n % PHASE_BEATS == 0) begin
                mode      = $urandom_range(MODE_FILL, MODE_BALANCED);
                idling_on = (n < RANDOM_BEATS - QUIET_TAIL) && ($urandom_range(0, 2) != 0);
            end
            issue(pick_op(mode), pick_word());
        end

        start <= 1'b0;
        while (open_count != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/cadq_pkg.sv
rtl/core/circular_array_deque_unit.sv
rtl/core/cadq_chk.sv
tb/sv/deque_checker.sv
tb/sv/tb_top.sv
